[hw/rtl/aeut_pkg.sv]
// Package for the absolute encoder unwrap tracker: field widths, beat structs,
// micro-operation codes and the microcode table of the control sequencer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package aeut_pkg;

  // Sensor and count sizing.
  localparam int RAW_RESOLUTION = 4096;
  localparam int COUNT_BITS     = 48;

  // Fixed field widths.
  localparam int RAW_W     = 12;
  localparam int EL_W      = 20;
  localparam int TURN_W    = 48;
  localparam int Q_W       = 32;
  localparam int SCALE_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd6588397;
  // Microseconds per second, the velocity numerator scale.
  localparam logic [SCALE_W-1:0] VEL_SCALE   = 32'd1000000;

  typedef struct packed {
    logic             func;
    logic [RAW_W-1:0] raw_angle;
    logic             read_ok;
    logic [EL_W-1:0]  elapsed_us;
  } sample_t;

  typedef struct packed {
    logic signed [TURN_W-1:0] turn_counts;
    logic signed [Q_W-1:0]    position;
    logic signed [Q_W-1:0]    velocity;
    logic [RAW_W-1:0]         last_raw;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [SCALE_W-1:0]   data;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_UNWRAP,
    UOP_ABS,
    UOP_MUL_HI,
    UOP_MUL_LO,
    UOP_POS,
    UOP_DELTA,
    UOP_MUL_V,
    UOP_ROUND,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_VEL,
    UOP_KEEPV,
    UOP_ZERO,
    UOP_EMIT
  } uop_t;

  // What a step waits on before the step counter moves.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT,
    HOLD_DIV
  } hold_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_REZERO,
    JC_EL_ZERO
  } jcond_t;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] PC_UNWRAP   = 4'd1;
  localparam logic [PC_W-1:0] PC_ABS      = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_HI   = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_LO   = 4'd4;
  localparam logic [PC_W-1:0] PC_POS      = 4'd5;
  localparam logic [PC_W-1:0] PC_DELTA    = 4'd6;
  localparam logic [PC_W-1:0] PC_MUL_V    = 4'd7;
  localparam logic [PC_W-1:0] PC_ROUND    = 4'd8;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd9;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd10;
  localparam logic [PC_W-1:0] PC_VEL      = 4'd11;
  localparam logic [PC_W-1:0] PC_KEEPV    = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd13;
  localparam logic [PC_W-1:0] PC_ZERO     = 4'd14;

  typedef struct packed {
    uop_t            uop;
    hold_t           hold;
    jcond_t          jc;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    uop_t uop;
    logic exec;
  } dp_ctrl_t;

  typedef struct packed {
    logic rezero;
    logic el_zero;
    logic div_last;
  } dp_stat_t;

  // The control program, one word per step.
  function automatic ucode_t aeut_ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_FETCH:    w = '{UOP_FETCH,    HOLD_IN,   JC_REZERO,  PC_ZERO};
      PC_UNWRAP:   w = '{UOP_UNWRAP,   HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_ABS:      w = '{UOP_ABS,      HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_MUL_HI:   w = '{UOP_MUL_HI,   HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_MUL_LO:   w = '{UOP_MUL_LO,   HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_POS:      w = '{UOP_POS,      HOLD_NONE, JC_EL_ZERO, PC_KEEPV};
      PC_DELTA:    w = '{UOP_DELTA,    HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_MUL_V:    w = '{UOP_MUL_V,    HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_ROUND:    w = '{UOP_ROUND,    HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_DIV_INIT: w = '{UOP_DIV_INIT, HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_DIV_STEP: w = '{UOP_DIV_STEP, HOLD_DIV,  JC_NEXT,    PC_FETCH};
      PC_VEL:      w = '{UOP_VEL,      HOLD_NONE, JC_ALWAYS,  PC_EMIT};
      PC_KEEPV:    w = '{UOP_KEEPV,    HOLD_NONE, JC_NEXT,    PC_FETCH};
      PC_EMIT:     w = '{UOP_EMIT,     HOLD_OUT,  JC_ALWAYS,  PC_FETCH};
      PC_ZERO:     w = '{UOP_ZERO,     HOLD_NONE, JC_ALWAYS,  PC_EMIT};
      default:     w = '{UOP_NOP,      HOLD_NONE, JC_ALWAYS,  PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/absolute_encoder_unwrap_tracker.sv]
// Top level of the absolute encoder unwrap tracker: microcoded step sequencer,
// beat handshakes and the result register. Depends on aeut_pkg and aeut_dpath.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  aeut_pkg::sample_t
// result    out        result_valid / result_ready  aeut_pkg::result_t
// config    in         cfg_write_en (no wait)       cfg_index, cfg_data
//
// A full update goes from its sample beat to the result register through
// nine single steps, 31 restoring-divider iterations for the velocity quotient,
// then the velocity and emit steps. Zero elapsed time skips the divide and
// keeps the held velocity; a re-zero (or the first beat after reset) takes the
// zero step alone. A beat is taken only after emit, which holds while the
// previous result is stalled. Reset is synchronous.

module absolute_encoder_unwrap_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  aeut_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output aeut_pkg::result_t                result,
  input  logic                             cfg_write_en,
  input  logic [aeut_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aeut_pkg::SCALE_W-1:0]     cfg_data
);
  import aeut_pkg::*;

  // Step counter and the control word it selects from the microcode table.
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          cw;
  dp_ctrl_t        ctrl;
  dp_stat_t        stat;
  cfg_wr_t         cfg;
  result_t         dp_res;
  logic            out_free;
  logic            go;
  logic            taken;

  assign cw = aeut_ucode(pc);

  // The result register may be loaded when empty or emptied in this cycle.
  assign out_free = ~result_valid | result_ready;

  // The sequencer waits at the fetch step for a sample beat.
  assign sample_ready = (cw.hold == HOLD_IN);

  always_comb begin
    case (cw.hold)
      HOLD_NONE: go = 1'b1;
      HOLD_IN:   go = sample_valid;
      HOLD_OUT:  go = out_free;
      HOLD_DIV:  go = stat.div_last;
      default:   go = 1'b1;
    endcase

    // Divider steps run every cycle; other waiting steps run once, on release.
    ctrl.exec = (cw.hold == HOLD_DIV) ? 1'b1 : go;
    ctrl.uop  = cw.uop;

    if (!go) begin
      pc_next = pc;
    end else begin
      case (cw.jc)
        JC_NEXT:    pc_next = pc + PC_W'(1);
        JC_ALWAYS:  pc_next = cw.target;
        JC_REZERO:  pc_next = stat.rezero ? cw.target : pc + PC_W'(1);
        JC_EL_ZERO: pc_next = stat.el_zero ? cw.target : pc + PC_W'(1);
        default:    pc_next = PC_FETCH;
      endcase
    end
  end

  assign taken = ctrl.exec & (cw.uop == UOP_EMIT);

  assign cfg.we    = cfg_write_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  aeut_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .sample (sample),
    .stat   (stat),
    .res    (dp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_FETCH;
      result_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (taken) begin
        result_valid <= 1'b1;
        result       <= dp_res;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // A sample beat always moves the sequencer off the fetch step.
  a_fetch_leaves : assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sequencer stayed at fetch after a sample beat");

  // A new result only appears out of the emit step.
  a_rise_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pc) == PC_EMIT)
    else $error("result raised outside the emit step");

  // The emit step waits while an earlier result is still stalled.
  a_emit_waits : assert property (@(posedge clk) disable iff (rst)
    pc == PC_EMIT && result_valid && !result_ready |=> pc == PC_EMIT)
    else $error("emit step passed a stalled result");

endmodule

`default_nettype wire

[hw/rtl/aeut_dpath.sv]
// Datapath of the unwrap tracker: tracker state, configuration registers,
// one shared 32x32 multiplier and a radix-2 restoring divider.
// Depends on aeut_pkg; driven step by step by the sequencer in the top level.
`default_nettype none

module aeut_dpath (
  input  logic               clk,
  input  logic               rst,
  input  aeut_pkg::dp_ctrl_t ctrl,
  input  aeut_pkg::cfg_wr_t  cfg,
  input  aeut_pkg::sample_t  sample,
  output aeut_pkg::dp_stat_t stat,
  output aeut_pkg::result_t  res
);
  import aeut_pkg::*;

  localparam int CNT_W    = COUNT_BITS;
  localparam int RAW_B    = $clog2(RAW_RESOLUTION);
  localparam int D_W      = ((RAW_B > RAW_W) ? RAW_B : RAW_W) + 2;
  localparam int MAG_W    = 64;
  localparam int HALF_W   = MAG_W / 2;
  localparam int PROD_W   = 64;
  localparam int DIV_BITS = Q_W - 1;
  localparam int ITER_W   = $clog2(DIV_BITS + 1);
  localparam int N_W      = Q_W + EL_W + 1;
  localparam int TOP_W    = N_W - DIV_BITS;

  localparam logic [RAW_W-1:0]      RAW_MASK = RAW_W'(RAW_RESOLUTION - 1);
  localparam logic signed [D_W-1:0] HALF     = D_W'(RAW_RESOLUTION / 2);
  localparam logic signed [D_W-1:0] FULL     = D_W'(RAW_RESOLUTION);
  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0]   Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]   Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};

  // Signed saturation of a sign and magnitude to Q_W bits.
  function automatic logic signed [Q_W-1:0] clamp_q(input logic neg,
                                                    input logic [MAG_W-1:0] mag);
    logic big;
    logic [Q_W-1:0] low;
    big = (mag[MAG_W-1:Q_W-1] != '0);
    low = mag[Q_W-1:0];
    if (neg) begin
      return big ? Q_MIN : $signed(Q_W'(0) - low);
    end
    return big ? Q_MAX : $signed(low);
  endfunction

  // Configuration.
  logic               reverse_dir;
  logic [SCALE_W-1:0] scale;

  // Tracker state.
  logic [RAW_W-1:0]        prev_raw;
  logic signed [CNT_W-1:0] total;
  logic signed [Q_W-1:0]   held_vel;
  logic signed [Q_W-1:0]   prev_pos;
  logic                    primed;

  // Working registers of one item.
  logic [RAW_W-1:0]      raw_cur;
  logic [EL_W-1:0]       el;
  logic signed [Q_W-1:0] pos;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic                  hi_ovf;
  logic [15:0]           hi16;
  logic [Q_W-1:0]        dp_mag;
  logic [N_W-1:0]        num;
  logic                  div_ovf;
  logic [EL_W-1:0]       rem;
  logic [DIV_BITS-1:0]   qsh;
  logic [ITER_W-1:0]     iter;

  // Sample selection: a failed read reuses the stored raw value.
  logic [RAW_W-1:0] raw_sel;
  assign raw_sel = sample.read_ok ? (sample.raw_angle & RAW_MASK) : prev_raw;

  // Unwrap and saturating count update.
  logic signed [D_W-1:0]   d_raw, d_wrap, d_dir;
  logic signed [CNT_W:0]   cnt_sum;
  logic signed [CNT_W-1:0] cnt_next;

  always_comb begin
    d_raw = $signed(D_W'(raw_cur)) - $signed(D_W'(prev_raw));
    if (d_raw > HALF) begin
      d_wrap = d_raw - FULL;
    end else if (d_raw < -HALF) begin
      d_wrap = d_raw + FULL;
    end else begin
      d_wrap = d_raw;
    end
    d_dir   = reverse_dir ? -d_wrap : d_wrap;
    cnt_sum = (CNT_W+1)'(total) + (CNT_W+1)'(d_dir);
    if (cnt_sum[CNT_W] != cnt_sum[CNT_W-1]) begin
      cnt_next = cnt_sum[CNT_W] ? CNT_MIN : CNT_MAX;
    end else begin
      cnt_next = cnt_sum[CNT_W-1:0];
    end
  end

  // Count magnitude.
  logic signed [MAG_W-1:0] cnt_ext;
  logic [MAG_W-1:0]        cnt_abs;
  assign cnt_ext = MAG_W'(total);
  assign cnt_abs = total[CNT_W-1] ? -cnt_ext : cnt_ext;

  // Shared multiplier.
  logic [HALF_W-1:0] mul_a;
  logic [SCALE_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    case (ctrl.uop)
      UOP_MUL_HI: mul_a = mag[MAG_W-1:HALF_W];
      UOP_MUL_LO: mul_a = mag[HALF_W-1:0];
      UOP_MUL_V:  mul_a = dp_mag;
      default:    mul_a = '0;
    endcase
    mul_b = (ctrl.uop == UOP_MUL_V) ? VEL_SCALE : scale;
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Position: rounded Q16.16 from the two partial products.
  logic [PROD_W:0]              round_lo;
  logic [MAG_W-1:0]             pos_mag;
  logic signed [Q_W-1:0]        pos_val;

  always_comb begin
    round_lo = (PROD_W+1)'(prod) + (PROD_W+1)'(17'h08000);
    pos_mag  = MAG_W'({hi16, 16'h0000}) + MAG_W'(round_lo[PROD_W:16]);
    pos_val  = hi_ovf ? clamp_q(neg, '1) : clamp_q(neg, pos_mag);
  end

  // Position change.
  logic signed [Q_W:0] dp, dp_abs;
  assign dp     = (Q_W+1)'(pos) - (Q_W+1)'(prev_pos);
  assign dp_abs = dp[Q_W] ? -dp : dp;

  // Divider.
  logic [TOP_W-1:0] num_top;
  logic [EL_W+1:0]  trial;
  logic             borrow;
  assign num_top = num[N_W-1:DIV_BITS];
  assign trial   = {1'b0, rem, qsh[DIV_BITS-1]} - (EL_W+2)'(el);
  assign borrow  = trial[EL_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_dir <= 1'b0;
      scale       <= SCALE_RESET;
      prev_raw    <= '0;
      total       <= '0;
      held_vel    <= '0;
      prev_pos    <= '0;
      primed      <= 1'b0;
      iter        <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          CFG_REVERSE: reverse_dir <= cfg.data[0];
          CFG_SCALE:   scale <= cfg.data;
          default:     ;
        endcase
      end
      if (ctrl.exec) begin
        case (ctrl.uop)
          UOP_FETCH: begin
            raw_cur <= raw_sel;
            el      <= sample.elapsed_us;
          end
          UOP_UNWRAP: begin
            total    <= cnt_next;
            prev_raw <= raw_cur;
          end
          UOP_ABS: begin
            neg <= total[CNT_W-1];
            mag <= cnt_abs;
          end
          UOP_MUL_HI: prod <= mul_p;
          UOP_MUL_LO: begin
            hi_ovf <= (prod[PROD_W-1:16] != '0);
            hi16   <= prod[15:0];
            prod   <= mul_p;
          end
          UOP_POS: pos <= pos_val;
          UOP_DELTA: begin
            neg    <= dp[Q_W];
            dp_mag <= dp_abs[Q_W-1:0];
          end
          UOP_MUL_V: prod <= mul_p;
          UOP_ROUND: num <= prod[N_W-1:0] + N_W'(el >> 1);
          UOP_DIV_INIT: begin
            // A quotient of 2^31 or more saturates, so only 31 bits are formed.
            div_ovf <= (num_top >= TOP_W'(el));
            rem     <= num_top[EL_W-1:0];
            qsh     <= num[DIV_BITS-1:0];
            iter    <= ITER_W'(DIV_BITS);
          end
          UOP_DIV_STEP: begin
            rem  <= borrow ? {rem[EL_W-2:0], qsh[DIV_BITS-1]} : trial[EL_W-1:0];
            qsh  <= {qsh[DIV_BITS-2:0], ~borrow};
            iter <= iter - ITER_W'(1);
          end
          UOP_VEL: begin
            held_vel <= div_ovf ? clamp_q(neg, '1) : clamp_q(neg, MAG_W'(qsh));
            prev_pos <= pos;
          end
          UOP_KEEPV: prev_pos <= pos;
          UOP_ZERO: begin
            prev_raw <= raw_cur;
            total    <= '0;
            held_vel <= '0;
            prev_pos <= '0;
            pos      <= '0;
            primed   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign stat.rezero   = sample.func | ~primed;
  assign stat.el_zero  = (el == '0);
  assign stat.div_last = (iter == ITER_W'(1));

  assign res.turn_counts = TURN_W'(total);
  assign res.position    = pos;
  assign res.velocity    = held_vel;
  assign res.last_raw    = prev_raw;

endmodule

`default_nettype wire
